/* design/chained_hash_set_unit_defines.svh */
// assertion helpers used by the checker file
`ifndef CHAINED_HASH_SET_UNIT_DEFINES_SVH
`define CHAINED_HASH_SET_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CHSU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CHSU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/chsu_pkg.sv */
package chsu_pkg;

    localparam int NUM_BUCKETS     = 11;
    localparam int WAYS_PER_BUCKET = 8;
    localparam int KEY_WIDTH       = 31;

    // fixed field widths of the stream words
    localparam int KEY_IN_W  = 31;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int BUCKET_W  = 4;
    localparam int S_TDATA_W = ((KEY_IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((BUCKET_W + 7) / 8) * 8;

    // modulo reduction: quotient by reciprocal multiplication, then remainder
    localparam int MOD_STEPS  = 2;
    localparam int DIG_W      = $clog2(MOD_STEPS);
    localparam int REC_SHIFT  = KEY_WIDTH + $clog2(NUM_BUCKETS);
    localparam int REC_MULT_W = KEY_WIDTH + 1;
    localparam int PROD_W     = KEY_WIDTH + REC_MULT_W;
    localparam logic [REC_MULT_W-1:0] REC_MULT = REC_MULT_W'(
        ((64'd1 << REC_SHIFT) + 64'(NUM_BUCKETS - 1)) / 64'(NUM_BUCKETS));
    localparam int REM_W   = $clog2(NUM_BUCKETS + 1);
    localparam int ROW_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic rd;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic mod_done;
        logic out_free;
    } dp_stat_t;

endpackage

/* design/chsu_ctrl.sv */
module chsu_ctrl
    import chsu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (stat.mod_done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                // hold until the result register can take the new word
                if (stat.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/chsu_datapath.sv */
module chsu_datapath
    import chsu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [KEY_IN_W-1:0] in_key,
    input  logic [KIND_W-1:0]   in_kind,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [BUCKET_W-1:0] out_bucket
);

    logic [KEY_WIDTH-1:0]      key_reg;
    logic [KIND_W-1:0]         kind_reg;
    logic [KEY_WIDTH-1:0]      quot_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [DIG_W-1:0]          dig_reg;
    logic [ROW_W-1:0]          row_idx;

    logic [PROD_W-1:0]         prod;
    logic [KEY_WIDTH-1:0]      quot_times_n;
    logic [KEY_WIDTH-1:0]      rem_full;

    logic [WAYS_PER_BUCKET-1:0][KEY_WIDTH-1:0] row_mem [NUM_BUCKETS];
    logic [WAYS_PER_BUCKET-1:0][KEY_WIDTH-1:0] row_q_reg;
    logic [WAYS_PER_BUCKET-1:0][KEY_WIDTH-1:0] row_wr;
    logic [WAYS_PER_BUCKET-1:0]                valid_reg [NUM_BUCKETS];

    logic [WAYS_PER_BUCKET-1:0] valid_row;
    logic [WAYS_PER_BUCKET-1:0] hit;
    logic [WAYS_PER_BUCKET-1:0] free;
    logic [WAYS_PER_BUCKET-1:0] free_oh;
    logic [WAYS_PER_BUCKET-1:0] valid_next;
    logic                       mem_we;
    logic [STATUS_W-1:0]        status_next;
    logic [BUCKET_W-1:0]        bucket_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BUCKET_W-1:0] out_bucket_reg;

    assign row_idx = rem_reg[ROW_W-1:0];

    // quotient from the reciprocal, remainder from the previous step's quotient
    assign prod         = PROD_W'(key_reg) * PROD_W'(REC_MULT);
    assign quot_times_n = quot_reg * KEY_WIDTH'(NUM_BUCKETS);
    assign rem_full     = key_reg - quot_times_n;

    // key intake and two-step modulo reduction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg   <= in_key[KEY_WIDTH-1:0];
            kind_reg  <= in_kind;
            rem_reg   <= '0;
        end else if (cmd.mod_step) begin
            quot_reg  <= KEY_WIDTH'(prod >> REC_SHIFT);
            rem_reg   <= rem_full[REM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dig_reg <= '0;
        end else if (cmd.load) begin
            dig_reg <= '0;
        end else if (cmd.mod_step) begin
            dig_reg <= dig_reg + 1'b1;
        end
    end

    // one bucket row per address
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            row_q_reg <= row_mem[row_idx];
        end
        if (cmd.exec && mem_we) begin
            row_mem[row_idx] <= row_wr;
        end
    end

    always_comb begin
        valid_row = valid_reg[row_idx];
        for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
            hit[w]    = valid_row[w] && (row_q_reg[w] == key_reg);
            row_wr[w] = row_q_reg[w];
        end
        free    = ~valid_row;
        // lowest free way only
        free_oh = free & (~free + WAYS_PER_BUCKET'(1));
        for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
            if (free_oh[w]) begin
                row_wr[w] = key_reg;
            end
        end
    end

    always_comb begin
        mem_we      = 1'b0;
        valid_next  = valid_row;
        status_next = STATUS_MISSING;
        unique case (kind_reg)
            KIND_INSERT: begin
                if (|hit) begin
                    status_next = STATUS_DUP;
                end else if (|free) begin
                    mem_we      = 1'b1;
                    valid_next  = valid_row | free_oh;
                    status_next = STATUS_DONE;
                end else begin
                    status_next = STATUS_FULL;
                end
            end
            KIND_SEARCH: begin
                status_next = (|hit) ? STATUS_DONE : STATUS_MISSING;
            end
            KIND_DELETE: begin
                if (|hit) begin
                    valid_next  = valid_row & ~hit;
                    status_next = STATUS_DONE;
                end
            end
            default: begin
                status_next = STATUS_MISSING;
            end
        endcase
        bucket_next = (status_next == STATUS_DONE) ? BUCKET_W'(rem_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                valid_reg[b] <= '0;
            end
        end else if (cmd.exec) begin
            valid_reg[row_idx] <= valid_next;
        end
    end

    // result register, parts the result side from the intake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_status_reg <= status_next;
            out_bucket_reg <= bucket_next;
        end
    end

    assign stat.mod_done = (dig_reg == DIG_W'(MOD_STEPS - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_bucket = out_bucket_reg;

endmodule

/* design/chained_hash_set_unit.sv */
// Set of integer keys in NUM_BUCKETS buckets of WAYS_PER_BUCKET ways each; a key lives
// in bucket key mod NUM_BUCKETS. Each input word carries an operation in s_tuser
// (insert, search, delete) and the key in s_tdata; each one yields exactly one result
// word with a status in m_tuser and, on success, the bucket index in m_tdata. One item
// is worked on at a time: the accept, the modulo reduction (quotient by
// reciprocal multiplication, then the remainder), the registered read of
// the bucket row, then the compare of all ways, write back and load of the result
// register; a new word is taken only once the last one has left the compare step, and a
// result still waiting on m_tready holds the compare step. A finished result may wait
// in its register while the next word is already taken in. The valid marks are cleared
// by reset in the same cycle; there is no clearing pass.
module chained_hash_set_unit
    import chsu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key
    input  logic [KIND_W-1:0]    s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // bucket
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [BUCKET_W-1:0] bucket;

    chsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    chsu_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_key     (s_tdata[KEY_IN_W-1:0]),
        .in_kind    (s_tuser),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_bucket (bucket)
    );

    assign m_tdata = M_TDATA_W'(bucket);

endmodule

/* design/chsu_checker.sv */
`include "chained_hash_set_unit_defines.svh"

module chsu_checker
    import chsu_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    logic in_take;
    logic out_stall;
    logic out_fail;
    logic bucket_ok;

    assign in_take   = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign out_fail  = m_tvalid && (m_tuser != STATUS_DONE);
    assign bucket_ok = (int'(m_tdata[BUCKET_W-1:0]) < NUM_BUCKETS)
                    && (m_tdata[M_TDATA_W-1:BUCKET_W] == '0);

    // a stalled result word holds
    `CHSU_ASSERT_NXT(a_out_hold, out_stall, m_tvalid && $stable({m_tdata, m_tuser}), "stall broke")

    // one item at a time: intake closes right after a word is taken
    `CHSU_ASSERT_NXT(a_one_in_flight, in_take, !s_tready, "intake stayed open after accept")

    // bucket is zero unless the operation succeeded
    `CHSU_ASSERT_IMP(a_bucket_zero, out_fail, m_tdata == '0, "bucket set on a failure")

    // bucket index stays below the bucket count
    `CHSU_ASSERT_IMP(a_bucket_range, m_tvalid, bucket_ok, "bucket index out of range")

endmodule

bind chained_hash_set_unit chsu_checker u_chsu_checker (.*);

/* test/chsu_result_checker.sv */
module chsu_result_checker
    import chsu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key
    input  logic [KIND_W-1:0]    s_tuser,   // kind
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // bucket
    input  logic [STATUS_W-1:0]  m_tuser,   // status
    output int                   mismatches,
    output int                   pending
);

    localparam int SLOTS = NUM_BUCKETS * WAYS_PER_BUCKET;
    localparam int SHOWN_ERRORS = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BUCKET_W-1:0] bucket;
    } hash_result_t;

    logic [KEY_WIDTH-1:0] stored_key [SLOTS];
    logic                 slot_used  [SLOTS];
    hash_result_t         expected_results [$];
    hash_result_t         want;
    int                   errs = 0;

    // applies one operation to the shadow table and returns its outcome
    function automatic hash_result_t apply_op(input logic [KIND_W-1:0] kind,
                                              input logic [KEY_WIDTH-1:0] key);
        hash_result_t r;
        int b;
        int hit;
        int free_way;
        int s;
        r.status = STATUS_MISSING;
        r.bucket = '0;
        b = int'(key % NUM_BUCKETS);
        hit = -1;
        free_way = -1;
        for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
            s = b * WAYS_PER_BUCKET + w;
            if (slot_used[s] && stored_key[s] == key && hit < 0)
                hit = w;
            if (!slot_used[s] && free_way < 0)
                free_way = w;
        end
        case (kind)
            KIND_INSERT: begin
                if (hit >= 0) begin
                    r.status = STATUS_DUP;
                end else if (free_way >= 0) begin
                    stored_key[b * WAYS_PER_BUCKET + free_way] = key;
                    slot_used[b * WAYS_PER_BUCKET + free_way] = 1'b1;
                    r.status = STATUS_DONE;
                    r.bucket = BUCKET_W'(b);
                end else begin
                    r.status = STATUS_FULL;
                end
            end
            KIND_SEARCH: begin
                if (hit >= 0) begin
                    r.status = STATUS_DONE;
                    r.bucket = BUCKET_W'(b);
                end
            end
            KIND_DELETE: begin
                if (hit >= 0) begin
                    slot_used[b * WAYS_PER_BUCKET + hit] = 1'b0;
                    r.status = STATUS_DONE;
                    r.bucket = BUCKET_W'(b);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
                stored_key[i] = '0;
            end
            expected_results.delete();
            pending <= 0;
        end else begin
            // result word first: it always belongs to an earlier input word
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    errs++;
                    if (errs <= SHOWN_ERRORS)
                        $display("%0t: unexpected result status=%0d bucket=%0d",
                                 $time, m_tuser, m_tdata[BUCKET_W-1:0]);
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== m_tuser
                        || want.bucket !== m_tdata[BUCKET_W-1:0]) begin
                        errs++;
                        if (errs <= SHOWN_ERRORS)
                            $display({"%0t: mismatch expected status=%0d bucket=%0d,",
                                      " got status=%0d bucket=%0d"},
                                     $time, want.status, want.bucket,
                                     m_tuser, m_tdata[BUCKET_W-1:0]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_op(s_tuser, s_tdata[KEY_WIDTH-1:0]));
            pending <= expected_results.size();
        end
        mismatches <= errs;
    end

endmodule

/* test/tb_chained_hash_set_unit.sv */
module tb_chained_hash_set_unit;
    import chsu_pkg::*;

    localparam int ITEM_COUNT   = 600;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 30;
    localparam int FAR_KEYS     = 12;

    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [KEY_WIDTH-1:0] KEY_MAX     = '1;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    int   mismatches;
    int   pending;
    logic calm = 1'b0;
    int   quiet_cycles = 0;
    logic [KEY_WIDTH-1:0] far_key [FAR_KEYS];

    chained_hash_set_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    chsu_result_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 20);
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // holds tvalid high across back-to-back words, except for random gaps outside calm
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [KEY_WIDTH-1:0] key);
        while (!calm && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'(key);
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    // small keys crowd the buckets, far keys exercise the upper bits
    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return KEY_WIDTH'($urandom_range(0, 120));
        else if (r < 85)
            return far_key[$urandom_range(0, FAR_KEYS - 1)];
        else
            return KEY_WIDTH'($urandom);
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return KIND_INSERT;
        else if (r < 70)
            return KIND_SEARCH;
        else if (r < 95)
            return KIND_DELETE;
        else
            return KIND_UNUSED;
    endfunction

    initial begin
        for (int i = 0; i < FAR_KEYS; i++)
            far_key[i] = KEY_WIDTH'($urandom);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(KIND_INSERT, '0);
        send_word(KIND_INSERT, KEY_MAX);
        send_word(KIND_INSERT, '0);
        send_word(KIND_SEARCH, KEY_MAX);
        send_word(KIND_SEARCH, KEY_WIDTH'(5));
        send_word(KIND_DELETE, KEY_WIDTH'(7));
        send_word(KIND_UNUSED, KEY_MAX);
        // fill the bucket of key zero, then overflow it
        for (int i = 1; i < WAYS_PER_BUCKET; i++)
            send_word(KIND_INSERT, KEY_WIDTH'(NUM_BUCKETS * i));
        send_word(KIND_INSERT, KEY_WIDTH'(NUM_BUCKETS * WAYS_PER_BUCKET));
        // remove a middle way and reuse it
        send_word(KIND_DELETE, KEY_WIDTH'(NUM_BUCKETS * 3));
        send_word(KIND_SEARCH, KEY_WIDTH'(NUM_BUCKETS * 3));
        send_word(KIND_INSERT, KEY_WIDTH'(NUM_BUCKETS * WAYS_PER_BUCKET));
        send_word(KIND_SEARCH, KEY_WIDTH'(NUM_BUCKETS * WAYS_PER_BUCKET));
        send_word(KIND_DELETE, '0);
        send_word(KIND_DELETE, KEY_MAX);
        wait_drained();

        for (int i = 0; i < ITEM_COUNT; i++) begin
            if (i == 300)
                wait_drained();
            calm <= (i >= 350 && i < 500);
            send_word(pick_kind(), pick_key());
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* chained_hash_set_unit.f */
+incdir+design
design/chsu_pkg.sv
design/chsu_ctrl.sv
design/chsu_datapath.sv
design/chained_hash_set_unit.sv
design/chsu_checker.sv
test/chsu_result_checker.sv
test/tb_chained_hash_set_unit.sv
